/* rtl/plsu_pkg.sv */
// Package for the positional list store: field widths, request and status
// codes, and the request and result structures used across the modules.
// No dependencies.
package plsu_pkg;

    // Default sizes handed to the top level.
    localparam int CAPACITY_DEF  = 64;
    localparam int WORD_BITS_DEF = 32;

    // Fixed field widths.
    localparam int REQ_W    = 3;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int ICOUNT_W = 7;

    // Stream data widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 112;

    // Depth of the queue between front and back; a power of two.
    localparam int Q_DEPTH = 2;

    // Request types as they arrive on the stream.
    localparam logic [REQ_W-1:0] REQ_APPEND   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_LAST = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ     = 3'd4;

    // Classified operations passed to the back end.
    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_TAKE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // One classified request.
    typedef struct packed {
        logic [1:0]        op;
        logic              to_end;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] word;
    } t_req;

    // One result item.
    typedef struct packed {
        logic                is_empty;
        logic [DATA_W-1:0]   last_word;
        logic [DATA_W-1:0]   first_word;
        logic [ICOUNT_W-1:0] item_count;
        logic [DATA_W-1:0]   data_out;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

/* rtl/plsu_front.sv */
// Front end of the positional list store: unpacks the input stream and
// classifies each request into an operation for the back end.
// Depends on plsu_pkg.
module plsu_front (
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [plsu_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                             i_q_full,
    output logic                             o_q_push,
    output plsu_pkg::t_req                   o_req
);
    import plsu_pkg::*;

    logic [REQ_W-1:0] req_type;

    // Field unpacking, lowest field first.
    assign req_type = i_s_tdata[REQ_W-1:0];

    // A transfer is taken whenever the queue has room.
    assign o_s_tready = !i_q_full;
    assign o_q_push   = i_s_tvalid && !i_q_full;

    // Map request types onto put, take, read or ignore.
    always_comb begin
        o_req.position = i_s_tdata[REQ_W+POS_W-1:REQ_W];
        o_req.word     = i_s_tdata[REQ_W+POS_W+DATA_W-1:REQ_W+POS_W];
        o_req.op       = OP_NOP;
        o_req.to_end   = 1'b0;
        unique case (req_type)
            REQ_APPEND: begin
                o_req.op     = OP_PUT;
                o_req.to_end = 1'b1;
            end
            REQ_INSERT: begin
                o_req.op = OP_PUT;
            end
            REQ_POP_LAST: begin
                o_req.op     = OP_TAKE;
                o_req.to_end = 1'b1;
            end
            REQ_REMOVE: begin
                o_req.op = OP_TAKE;
            end
            REQ_READ: begin
                o_req.op = OP_READ;
            end
            default: begin
                o_req.op = OP_NOP;
            end
        endcase
    end

endmodule

/* rtl/plsu_queue.sv */
// Short request queue between the front and back ends of the positional
// list store. Depends on plsu_pkg.
module plsu_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  plsu_pkg::t_req i_req,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output plsu_pkg::t_req o_req
);
    import plsu_pkg::*;

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_req           r_q [Q_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    logic           pop_ok;

    assign o_full  = (r_cnt == QCW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_q[r_rp];
    assign pop_ok  = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_req;
        end
    end

    // Pointers and fill level; the depth is a power of two, so they wrap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && pop_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/plsu_exec.sv */
// Back end of the positional list store: the slot memory, the sequencer
// that shifts words for insert and removal, and the result register.
// Depends on plsu_pkg.
module plsu_exec #(
    parameter int CAPACITY  = plsu_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = plsu_pkg::WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  plsu_pkg::t_req    i_req,
    output logic              o_req_pop,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output plsu_pkg::t_result o_res
);
    import plsu_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_ENDS  = 2'd2;
    localparam logic [1:0] S_FETCH = 2'd3;

    // Kinds of list change.
    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_INS  = 2'd1;
    localparam logic [1:0] K_REM  = 2'd2;

    logic [WORD_BITS-1:0] r_slots [CAPACITY];
    logic [WORD_BITS-1:0] r_rd_a;
    logic [WORD_BITS-1:0] r_rd_b;

    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [1:0]           r_kind, n_kind;
    logic [AW-1:0]        r_idx, n_idx;
    logic [AW-1:0]        r_stop, n_stop;
    logic                 r_grab, n_grab;
    logic                 r_pend, n_pend;
    logic [AW-1:0]        r_wr_addr, n_wr_addr;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [WORD_BITS-1:0] r_data, n_data;
    logic [WORD_BITS-1:0] r_word, n_word;
    logic                 r_res_valid;
    t_result              r_res;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        addr_a;
    logic [AW-1:0]        addr_b;

    logic [CW+POS_W-1:0]  pos_w;
    logic [CW+POS_W-1:0]  cnt_w;
    logic                 pos_ge;
    logic                 is_full;
    logic                 is_zero;
    logic                 at_end;
    logic [AW-1:0]        put_pos;
    logic [AW-1:0]        take_pos;
    logic [AW-1:0]        last_idx;
    logic                 more;
    logic                 res_load;
    logic [WORD_BITS+DATA_W-1:0] word_in_ext;
    logic [WORD_BITS+DATA_W-1:0] data_ext;
    logic [WORD_BITS+DATA_W-1:0] first_ext;
    logic [WORD_BITS+DATA_W-1:0] last_ext;
    logic [CW+ICOUNT_W-1:0]      count_ext;

    // Request decode against the current count.
    assign pos_w    = {{CW{1'b0}}, i_req.position};
    assign cnt_w    = {{POS_W{1'b0}}, r_count};
    assign pos_ge   = (pos_w >= cnt_w);
    assign is_full  = (r_count == CW'(CAPACITY));
    assign is_zero  = (r_count == '0);
    assign at_end   = i_req.to_end || pos_ge;
    assign last_idx = AW'(r_count - 1'b1);
    assign put_pos  = at_end ? AW'(r_count) : AW'(i_req.position);
    assign take_pos = at_end ? last_idx : AW'(i_req.position);

    // Incoming word cut or padded to the slot width.
    assign word_in_ext = {{WORD_BITS{1'b0}}, i_req.word};

    // A shift step remains while the index has not reached its stop.
    always_comb begin
        case (r_kind)
            K_INS:   more = (r_idx > r_stop);
            K_REM:   more = (r_idx < r_stop);
            default: more = 1'b0;
        endcase
    end

    assign o_req_pop = (r_state == S_IDLE) && i_req_valid;
    assign res_load  = (r_state == S_FETCH) && (!r_res_valid || i_res_ready);
    assign addr_b    = last_idx;

    // Sequencer next state, memory port A address and the write port.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_kind    = r_kind;
        n_idx     = r_idx;
        n_stop    = r_stop;
        n_grab    = 1'b0;
        n_pend    = 1'b0;
        n_wr_addr = r_wr_addr;
        n_status  = r_status;
        n_data    = r_data;
        n_word    = r_word;
        addr_a    = '0;
        mem_we    = 1'b0;
        mem_waddr = r_wr_addr;
        mem_wdata = r_rd_a;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state  = S_SHIFT;
                    n_kind   = K_NONE;
                    n_status = ST_OK;
                    n_data   = '0;
                    n_word   = word_in_ext[WORD_BITS-1:0];
                    case (i_req.op)
                        OP_PUT: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_kind = K_INS;
                                n_idx  = AW'(r_count);
                                n_stop = put_pos;
                            end
                        end
                        OP_TAKE: begin
                            if (is_zero) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_kind = K_REM;
                                n_idx  = take_pos;
                                n_stop = last_idx;
                                n_grab = 1'b1;
                                addr_a = take_pos;
                            end
                        end
                        OP_READ: begin
                            if (pos_ge) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_grab = 1'b1;
                                addr_a = AW'(i_req.position);
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // The word read last cycle is either the answer or a shifted word.
                if (r_grab) begin
                    n_data = r_rd_a;
                end
                if (r_pend) begin
                    mem_we = 1'b1;
                end
                if (more) begin
                    n_pend    = 1'b1;
                    n_wr_addr = r_idx;
                    if (r_kind == K_INS) begin
                        addr_a = r_idx - 1'b1;
                        n_idx  = r_idx - 1'b1;
                    end else begin
                        addr_a = r_idx + 1'b1;
                        n_idx  = r_idx + 1'b1;
                    end
                end else if (!r_pend) begin
                    // All shifts written back; place the new word and settle the count.
                    n_state = S_ENDS;
                    if (r_kind == K_INS) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_stop;
                        mem_wdata = r_word;
                        n_count   = r_count + 1'b1;
                    end else if (r_kind == K_REM) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            S_ENDS: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                if (res_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Slot memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slots[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= r_slots[addr_a];
        r_rd_b <= r_slots[addr_b];
    end

    // Sequencer control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_kind  <= K_NONE;
            r_grab  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_kind  <= n_kind;
            r_grab  <= n_grab;
            r_pend  <= n_pend;
        end
    end

    // Sequencer payload registers.
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_stop    <= n_stop;
        r_wr_addr <= n_wr_addr;
        r_status  <= n_status;
        r_data    <= n_data;
        r_word    <= n_word;
    end

    // Result fields sized to the stream widths.
    assign data_ext  = {{DATA_W{1'b0}}, r_data};
    assign first_ext = {{DATA_W{1'b0}}, r_rd_a};
    assign last_ext  = {{DATA_W{1'b0}}, r_rd_b};
    assign count_ext = {{ICOUNT_W{1'b0}}, r_count};

    // Result register; the next request runs while it waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_load) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res.status     <= r_status;
            r_res.data_out   <= data_ext[DATA_W-1:0];
            r_res.item_count <= count_ext[ICOUNT_W-1:0];
            r_res.first_word <= is_zero ? '0 : first_ext[DATA_W-1:0];
            r_res.last_word  <= is_zero ? '0 : last_ext[DATA_W-1:0];
            r_res.is_empty   <= is_zero;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list count above capacity");

    // No shifted word is left unwritten when a request finishes.
    a_no_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend)
        else $error("shift write pending in idle");

    // The count only moves at the end of the shift phase.
    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_count)) |-> ($past(r_state) == S_SHIFT))
        else $error("count changed outside the shift phase");

    // A full status is only reported for a full list.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_load && (r_status == ST_FULL)) |-> is_full)
        else $error("full status with room left");

endmodule

/* rtl/positional_list_store_unit.sv */
// Top level of the positional list store: front end, request queue and
// back end joined to the input and result streams.
// Depends on plsu_pkg, plsu_front, plsu_queue and plsu_exec.
//
//  Channel   Direction  Contents of tdata (lowest bit first)
//  s_axis    in         req_type[2:0], position[10:3], data_in[42:11]
//  m_axis    out        status[1:0], data_out[33:2], item_count[40:34],
//                       first_word[72:41], last_word[104:73], is_empty[105]
//
// In the back end a request passes through the idle, shift, ends and fetch
// states; the shift state moves the words of an insert or removal (up to
// CAPACITY - 1) one at a time, as the slot memory has a single write port.
// Reset is synchronous and active low; the slot memory is not cleared.
// A two-entry queue lets the input side keep taking requests while the back
// end works, and the result register holds a result while the next runs.
module positional_list_store_unit #(
    parameter int CAPACITY  = plsu_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = plsu_pkg::WORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // req_type, position, data_in
    input  logic [plsu_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // status, data_out, item_count, first_word, last_word, is_empty
    output logic [plsu_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import plsu_pkg::*;

    localparam int RES_W = $bits(t_result);

    t_req    front_req;
    t_req    queue_req;
    logic    q_push;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    t_result res;

    // Classify incoming transfers.
    plsu_front u_front (
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_req      (front_req)
    );

    // Decouple the front from the back end.
    plsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_req   (front_req),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_req   (queue_req)
    );

    // Carry out list operations.
    plsu_exec #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (q_valid),
        .i_req       (queue_req),
        .o_req_pop   (q_pop),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (res)
    );

    // Pack the result, padded with zeros to whole bytes.
    assign o_m_axis_tdata = {{(OUT_TDATA_W - RES_W){1'b0}}, res};

endmodule

/* sim/plsu_list_checker.sv */
// Checker for the positional list store: watches the request and result streams,
// keeps its own copy of the list, and compares every result with the prediction.
// Depends on plsu_pkg.
module plsu_list_checker #(
    parameter int CAPACITY = plsu_pkg::CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    // req_type, position, data_in
    input  logic [plsu_pkg::IN_TDATA_W-1:0]  i_in_data,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    // status, data_out, item_count, first_word, last_word, is_empty
    input  logic [plsu_pkg::OUT_TDATA_W-1:0] i_out_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import plsu_pkg::*;

    // Shadow copy of the list; only entries below word_count are ever read.
    logic [DATA_W-1:0] list_words [CAPACITY];
    int                word_count = 0;

    t_result expected_results [$];
    int      fail_count    = 0;
    int      pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // Apply one request to the shadow list and build the result it must produce.
    task automatic apply_request(input logic [REQ_W-1:0] req_type,
                                 input logic [POS_W-1:0] position,
                                 input logic [DATA_W-1:0] word,
                                 output t_result res);
        int slot;
        int i;
        res = '0;
        res.status = ST_OK;
        case (req_type)
            REQ_APPEND, REQ_INSERT: begin
                if (word_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    // A position at or past the end appends.
                    slot = (req_type == REQ_APPEND || int'(position) > word_count) ?
                           word_count : int'(position);
                    for (i = word_count; i > slot; i--) list_words[i] = list_words[i-1];
                    list_words[slot] = word;
                    word_count++;
                end
            end
            REQ_POP_LAST, REQ_REMOVE: begin
                if (word_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // A position at or past the end takes the last word.
                    slot = (req_type == REQ_POP_LAST || int'(position) >= word_count) ?
                           word_count - 1 : int'(position);
                    res.data_out = list_words[slot];
                    for (i = slot; i + 1 < word_count; i++) list_words[i] = list_words[i+1];
                    word_count--;
                end
            end
            REQ_READ: begin
                if (int'(position) >= word_count) res.status = ST_RANGE;
                else res.data_out = list_words[position];
            end
            default: begin
                // Unknown request types leave the list alone and answer ok.
            end
        endcase
        res.item_count = ICOUNT_W'(word_count);
        res.first_word = (word_count != 0) ? list_words[0] : '0;
        res.last_word  = (word_count != 0) ? list_words[word_count-1] : '0;
        res.is_empty   = (word_count == 0);
    endtask

    task automatic check_field(input string field_name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0h, actual %0h", field_name, want, seen);
            fail_count++;
        end
    endtask

    // Predict on each request transfer, compare on each result transfer.
    always @(posedge i_clk) begin : monitor
        t_result predicted;
        t_result observed;
        t_result oldest;
        if (!i_rst_n) begin
            word_count = 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                apply_request(i_in_data[REQ_W-1:0], i_in_data[REQ_W +: POS_W],
                              i_in_data[REQ_W+POS_W +: DATA_W], predicted);
                expected_results.push_back(predicted);
            end
            if (i_out_valid && i_out_ready) begin
                observed = i_out_data[$bits(t_result)-1:0];
                if (expected_results.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    fail_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("status",     DATA_W'(oldest.status),     DATA_W'(observed.status));
                    check_field("data_out",   oldest.data_out,            observed.data_out);
                    check_field("item_count", DATA_W'(oldest.item_count),
                                DATA_W'(observed.item_count));
                    check_field("first_word", oldest.first_word,          observed.first_word);
                    check_field("last_word",  oldest.last_word,           observed.last_word);
                    check_field("is_empty",   DATA_W'(oldest.is_empty),   DATA_W'(observed.is_empty));
                end
            end
        end
        pending_count = expected_results.size();
    end

endmodule

/* sim/tb.sv */
// Testbench top for the positional list store: clock, reset, request stimulus
// and result back-pressure, with the checker beside the block giving the verdict.
// Depends on plsu_pkg, positional_list_store_unit and plsu_list_checker.
module tb;
    import plsu_pkg::*;

    localparam int ITEMS_PER_MIX = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 150;
    localparam int RUN_LIMIT     = 4_000_000;

    // Request mixes that steer the list toward half full, full or empty.
    typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} t_mix;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic [IN_TDATA_W-1:0]  in_data   = '0;
    logic                   out_ready = 1'b0;
    logic                   in_ready;
    logic                   out_valid;
    logic [OUT_TDATA_W-1:0] out_data;

    int fail_count;
    int pending;
    int tx_gap_pct    = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    always #2 clk = ~clk;

    positional_list_store_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data)
    );

    plsu_list_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != hold_served) begin
            out_ready   <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Offer one request, after a random gap, and wait for its transfer.
    task automatic send_request(input logic [REQ_W-1:0] req_type,
                                input logic [POS_W-1:0] position,
                                input logic [DATA_W-1:0] word);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {{(IN_TDATA_W-REQ_W-POS_W-DATA_W){1'b0}}, word, position, req_type};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic random_request(input t_mix mix);
        int                 pick;
        logic [REQ_W-1:0]   req_type;
        logic [POS_W-1:0]   position;
        int                 t_unknown, t_append, t_insert, t_pop, t_remove;
        case (mix)
            MIX_FILL:  begin t_unknown = 2; t_append = 40; t_insert = 80; t_pop = 85; t_remove = 90; end
            MIX_DRAIN: begin t_unknown = 2; t_append = 7;  t_insert = 12; t_pop = 45; t_remove = 80; end
            default:   begin t_unknown = 3; t_append = 23; t_insert = 43; t_pop = 58; t_remove = 78; end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < t_unknown)     req_type = REQ_W'(REQ_READ + $urandom_range(1, 3));
        else if (pick < t_append) req_type = REQ_APPEND;
        else if (pick < t_insert) req_type = REQ_INSERT;
        else if (pick < t_pop)    req_type = REQ_POP_LAST;
        else if (pick < t_remove) req_type = REQ_REMOVE;
        else                      req_type = REQ_READ;
        // Mostly positions near the live range, sometimes anywhere.
        position = ($urandom_range(0, 9) == 0) ? POS_W'($urandom_range(0, 255))
                                                : POS_W'($urandom_range(0, 70));
        send_request(req_type, position, $urandom);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Empty list: reads are out of range, removals report empty.
        send_request(REQ_READ, 8'd0, 32'h0);
        send_request(REQ_POP_LAST, 8'd0, 32'h0);
        send_request(REQ_REMOVE, 8'd255, 32'h0);
        // Unknown request types change nothing.
        for (int code = REQ_READ + 1; code < 8; code++) send_request(REQ_W'(code), 8'd0, 32'h0);
        // Build a short list with extreme words and positions.
        send_request(REQ_APPEND, 8'd0, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 8'd0, 32'h0000_0000);
        send_request(REQ_INSERT, 8'd255, 32'hA5A5_A5A5);
        send_request(REQ_INSERT, 8'd1, 32'h1234_5678);
        send_request(REQ_READ, 8'd0, 32'h0);
        send_request(REQ_READ, 8'd3, 32'h0);
        send_request(REQ_READ, 8'd4, 32'h0);
        send_request(REQ_READ, 8'd255, 32'h0);
        // Removal in the middle, past the end, at the end and at the front.
        send_request(REQ_REMOVE, 8'd1, 32'h0);
        send_request(REQ_REMOVE, 8'd255, 32'h0);
        send_request(REQ_POP_LAST, 8'd0, 32'h0);
        send_request(REQ_REMOVE, 8'd0, 32'h0);
        send_request(REQ_READ, 8'd0, 32'h0);

        // Long result hold-off while requests keep coming, to fill the block.
        hold_requests++;

        // Random traffic under each idling pattern, each through all mixes.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_gap_pct = 59; rx_stall_pct = 0;  end
                2:       begin tx_gap_pct = 0;  rx_stall_pct = 59; end
                default: begin tx_gap_pct = 14; rx_stall_pct = 14; end
            endcase
            repeat (ITEMS_PER_MIX) random_request(MIX_BALANCED);
            repeat (ITEMS_PER_MIX) random_request(MIX_FILL);
            repeat (ITEMS_PER_MIX) random_request(MIX_DRAIN);
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #RUN_LIMIT;
        $display("tb failed");
        $finish;
    end

endmodule
